>>> hdl/stq_pkg.sv
// Shared types, constants and codes for the sorted timer event queue.
// No dependencies; imported by stq_cell, stq_rem_div and sorted_timer_event_queue.
`default_nettype none

package stq_pkg;

    // Field widths
    localparam int unsigned TIME_W = 64;
    localparam int unsigned TAG_W  = 16;
    localparam int unsigned IV_W   = 32;
    localparam int unsigned DSEC_W = 32;

    // Stream word widths (padded to whole bytes)
    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 88;

    // Queue sizing
    localparam int unsigned POOL_DEPTH_DEF = 32;
    localparam int unsigned FIRE_LIMIT     = 32;
    localparam int unsigned POP_CNT_W      = $clog2(FIRE_LIMIT + 1);

    // Register reset values
    localparam logic [IV_W-1:0] TICK_INTERVAL_RST = 32'd750000;
    localparam logic [IV_W-1:0] TICKS_PER_SEC_RST = 32'd24000000;

    // Register indexes
    localparam logic CFG_TICK_INTERVAL = 1'b0;
    localparam logic CFG_TICKS_PER_SEC = 1'b1;

    // Request codes
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_ADD     = 2'd1;
    localparam logic [1:0] REQ_SERVICE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_COMPARE = 2'd2;

    // Add status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // One queue entry as held by a cell
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] expiry;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic              clear;
        logic              insert;
        logic              pop;
        logic [TIME_W-1:0] new_exp;
        logic [TAG_W-1:0]  new_tag;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hdl/stq_cell.sv
// One cell of the sorted chain: holds one pending event, shifts toward the
// tail on insert and toward the head on pop. Depends on stq_pkg.
`default_nettype none

module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_ctrl i_ctrl,
    input  stq_pkg::t_entry    i_prev,     // neighbor nearer the head
    input  logic               i_prev_gt,  // neighbor is later than the new event
    input  stq_pkg::t_entry    i_next,     // neighbor nearer the tail
    output stq_pkg::t_entry    o_entry,
    output logic               o_gt        // this cell is empty or later than new event
);
    import stq_pkg::*;

    logic              r_valid;
    logic [TIME_W-1:0] r_exp;
    logic [TAG_W-1:0]  r_tag;
    t_entry            n_entry;

    assign o_entry = '{valid: r_valid, expiry: r_exp, tag: r_tag};

    // Empty cells count as later than anything; equal expiry stays in front
    assign o_gt = !r_valid || (r_exp > i_ctrl.new_exp);

    // Next content
    always_comb begin
        n_entry = o_entry;
        priority if (i_ctrl.clear) begin
            n_entry.valid = 1'b0;
        end else if (i_ctrl.insert) begin
            if (o_gt) begin
                if (i_prev_gt) begin
                    n_entry = i_prev;
                end else begin
                    n_entry.valid  = 1'b1;
                    n_entry.expiry = i_ctrl.new_exp;
                    n_entry.tag    = i_ctrl.new_tag;
                end
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_next;
        end
    end

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_exp <= n_entry.expiry;
        r_tag <= n_entry.tag;
    end

endmodule

`default_nettype wire

>>> hdl/stq_rem_div.sv
// Bit-serial remainder unit: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on stq_pkg.
`default_nettype none

module stq_rem_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stq_pkg::TIME_W-1:0]  i_dividend,
    input  logic [stq_pkg::IV_W-1:0]    i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [stq_pkg::IV_W-1:0]    o_rem
);
    import stq_pkg::*;

    localparam int unsigned CNT_W = $clog2(TIME_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_dvd;
    logic [IV_W-1:0]   r_dsr;
    logic [IV_W-1:0]   r_rem;
    logic [IV_W-1:0]   n_rem;
    logic [IV_W:0]     w_trial;
    logic [IV_W:0]     w_diff;
    logic              w_ge;

    // Restoring step: bring in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[TIME_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign n_rem   = w_ge ? w_diff[IV_W-1:0] : w_trial[IV_W-1:0];

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy || r_done;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> hdl/sorted_timer_event_queue.sv
// Sorted timer event queue: top level with request sequencer, cell chain,
// tick deadline and output register. Depends on stq_pkg, stq_cell, stq_rem_div.
//
// Usage
//   Requests enter on the s_axis channel, one word per request; tuser is the
//   request code (start, add, service). Results leave on the m_axis channel,
//   tuser the result kind, tlast set on the final result of a request.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user
//   must write them only while idle, which the block does not enforce.
// Sequencing
//   One request is worked at a time; s_axis_tready is high only when idle.
//   Start: clears the chain on accept, compare result registered from S_FINAL.
//   Add: multiply, sum and sorted insert (rejects give a status from S_STATUS);
//   the insert is a single step in the cell chain whatever the occupancy.
//   Service: one expired event popped per cycle from the chain head while the
//   receiver takes results; when the tick deadline needs catching up, the
//   bit-serial remainder unit takes 64 steps alongside the pops, and the final
//   result waits for both.
// Reset clears the queue, the tick deadline and the output valid flag. A
// stalled receiver holds the output register and the sequencer waits.
`default_nettype none

module sorted_timer_event_queue #(
    parameter int unsigned POOL_DEPTH = stq_pkg::POOL_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [stq_pkg::IV_W-1:0]           i_cfg_wdata,
    // request stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: now_time[63:0], delay_sec[95:64], has_callback[96], event_tag[112:97]
    input  logic [stq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                         i_s_axis_tuser,
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: add_status[1:0], fired_tag[17:2], compare_valid[18], compare_value[82:19]
    output logic [stq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import stq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_INSERT = 7'b0001000,
        S_STATUS = 7'b0010000,
        S_POP    = 7'b0100000,
        S_FINAL  = 7'b1000000
    } t_state;

    localparam logic [POOL_DEPTH-1:0] VEC_ONE = POOL_DEPTH'(1);
    localparam int unsigned PROD_W = TIME_W - 1;

    // Input word fields
    logic              w_in_fire;
    logic [TIME_W-1:0] w_in_now;
    logic [DSEC_W-1:0] w_in_dsec;
    logic              w_in_cb;
    logic [TAG_W-1:0]  w_in_tag;

    // Sequencer and request registers
    t_state                r_state, n_state;
    logic [TIME_W-1:0]     r_now;
    logic [DSEC_W-2:0]     r_dsec;
    logic [TAG_W-1:0]      r_tag;
    logic [1:0]            r_status;
    logic [TIME_W-1:0]     r_prod;
    logic [TIME_W-1:0]     r_exp;
    logic [POP_CNT_W-1:0]  r_pop_cnt;
    logic [TIME_W-1:0]     r_deadline;
    logic [IV_W-1:0]       r_iv;
    logic [IV_W-1:0]       r_tps;

    logic [TIME_W-2:0]     w_prod;
    logic [IV_W-1:0]       w_iv_eff;

    // Output register
    logic              r_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [1:0]        r_out_status, n_out_status;
    logic [TAG_W-1:0]  r_out_tag, n_out_tag;
    logic              r_out_cv, n_out_cv;
    logic [TIME_W-1:0] r_out_val, n_out_val;
    logic              r_out_last, n_out_last;
    logic              w_out_free;
    logic              w_load;

    // Cell chain
    t_cell_ctrl        w_ctrl;
    t_entry            w_entry [POOL_DEPTH];
    logic              w_gt    [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] w_vld;
    t_entry            w_head;
    logic              w_full;
    logic              w_can_pop;
    logic [TIME_W-1:0] w_cmp;
    logic [TIME_W-1:0] w_ins_cmp;

    // Remainder unit
    logic              w_div_start;
    logic              w_div_busy;
    logic              w_div_done;
    logic [IV_W-1:0]   w_div_rem;

    // Input unpacking
    assign w_in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_now  = i_s_axis_tdata[63:0];
    assign w_in_dsec = i_s_axis_tdata[95:64];
    assign w_in_cb   = i_s_axis_tdata[96];
    assign w_in_tag  = i_s_axis_tdata[112:97];

    assign o_s_axis_tready = (r_state == S_IDLE);

    // A zero interval acts as one
    assign w_iv_eff = (r_iv == '0) ? IV_W'(1) : r_iv;

    // Seconds to ticks: 31 x 32 bit product
    assign w_prod = PROD_W'(r_dsec) * PROD_W'(r_tps);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv  <= TICK_INTERVAL_RST;
            r_tps <= TICKS_PER_SEC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_INTERVAL: r_iv  <= i_cfg_wdata;
                CFG_TICKS_PER_SEC: r_tps <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Cell chain
    for (genvar gi = 0; gi < POOL_DEPTH; gi++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_gt;
        t_entry w_next;

        if (gi == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_entry[gi-1];
            assign w_prev_gt = w_gt[gi-1];
        end

        if (gi == POOL_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_entry[gi+1];
        end

        stq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_entry   (w_entry[gi]),
            .o_gt      (w_gt[gi])
        );

        assign w_vld[gi] = w_entry[gi].valid;
    end

    assign w_head    = w_entry[0];
    assign w_full    = w_vld[POOL_DEPTH-1];
    assign w_can_pop = (r_pop_cnt < POP_CNT_W'(FIRE_LIMIT)) && w_head.valid &&
                       (w_head.expiry <= r_now);

    // Compare value: earlier of head expiry and tick deadline
    assign w_cmp     = (w_head.valid && (w_head.expiry < r_deadline)) ? w_head.expiry
                                                                       : r_deadline;
    assign w_ins_cmp = (r_exp < r_deadline) ? r_exp : r_deadline;

    // Tick deadline remainder unit
    stq_rem_div u_rem_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_in_now - r_deadline),
        .i_divisor  (w_iv_eff),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Sequencer
    always_comb begin
        n_state        = r_state;
        w_load         = 1'b0;
        w_div_start    = 1'b0;
        n_out_kind     = KIND_STATUS;
        n_out_status   = ST_OK;
        n_out_tag      = '0;
        n_out_cv       = 1'b0;
        n_out_val      = '0;
        n_out_last     = 1'b1;
        w_ctrl.clear   = 1'b0;
        w_ctrl.insert  = 1'b0;
        w_ctrl.pop     = 1'b0;
        w_ctrl.new_exp = r_exp;
        w_ctrl.new_tag = r_tag;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_s_axis_tuser)
                        REQ_START: begin
                            w_ctrl.clear = 1'b1;
                            n_state      = S_FINAL;
                        end
                        REQ_ADD: begin
                            if (!w_in_cb || w_in_dsec[DSEC_W-1] || w_full) begin
                                n_state = S_STATUS;
                            end else begin
                                n_state = S_MUL;
                            end
                        end
                        REQ_SERVICE: begin
                            w_div_start = (r_deadline <= w_in_now);
                            n_state     = S_POP;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: n_state = S_SUM;
            S_SUM: n_state = S_INSERT;
            S_INSERT: begin
                if (w_out_free) begin
                    w_ctrl.insert = 1'b1;
                    w_load        = 1'b1;
                    n_out_cv      = w_gt[0];
                    n_out_val     = w_gt[0] ? w_ins_cmp : '0;
                    n_state       = S_IDLE;
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    w_load       = 1'b1;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            S_POP: begin
                if (w_can_pop) begin
                    if (w_out_free) begin
                        w_ctrl.pop = 1'b1;
                        w_load     = 1'b1;
                        n_out_kind = KIND_FIRED;
                        n_out_tag  = w_head.tag;
                        n_out_last = 1'b0;
                    end
                end else if (!w_div_busy) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_out_kind = KIND_COMPARE;
                    n_out_cv   = 1'b1;
                    n_out_val  = w_cmp;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deadline  <= '0;
            r_pop_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Tick deadline: set on start, caught up after the remainder
            if (w_in_fire && (i_s_axis_tuser == REQ_START)) begin
                r_deadline <= w_in_now + TIME_W'(w_iv_eff);
            end else if (w_div_done) begin
                r_deadline <= r_now + TIME_W'(w_iv_eff - w_div_rem);
            end

            if (w_in_fire) begin
                r_pop_cnt <= '0;
            end else if (w_ctrl.pop) begin
                r_pop_cnt <= r_pop_cnt + POP_CNT_W'(1);
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and arithmetic
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_now    <= w_in_now;
            r_dsec   <= w_in_dsec[DSEC_W-2:0];
            r_tag    <= w_in_tag;
            r_status <= (!w_in_cb || w_in_dsec[DSEC_W-1]) ? ST_INVALID : ST_FULL;
        end
        if (r_state == S_MUL) begin
            r_prod <= {1'b0, w_prod};
        end
        if (r_state == S_SUM) begin
            r_exp <= r_now + r_prod;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind   <= n_out_kind;
            r_out_status <= n_out_status;
            r_out_tag    <= n_out_tag;
            r_out_cv     <= n_out_cv;
            r_out_val    <= n_out_val;
            r_out_last   <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_val, r_out_cv, r_out_tag, r_out_status};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // Occupied cells always form one run from the head
    a_occupancy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld + VEC_ONE) & w_vld) == '0)
        else $error("cell occupancy has a gap");

    // The remainder unit only runs inside a service request
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_busy)
        else $error("remainder unit busy while idle");

    // Only fired events continue a request; every other result ends it
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser != KIND_FIRED)))
        else $error("tlast does not match result kind");

    // An insert never runs into a full chain
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.insert |-> !w_full)
        else $error("insert into full chain");

    // A pop releases only an expired head
    a_pop_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |-> (w_head.valid && (w_head.expiry <= r_now)))
        else $error("pop of a head that has not expired");

endmodule

`default_nettype wire

>>> tb/sorted_timer_event_queue_test.sv
// Self-checking testbench for sorted_timer_event_queue: a directed table and
// random request phases; results checked against a local predictor or table rows.
// Depends on stq_pkg and the sorted_timer_event_queue RTL.
`timescale 1ns / 1ps

module sorted_timer_event_queue_test;
    import stq_pkg::*;

    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam logic [63:0] TIME_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          POOL        = POOL_DEPTH_DEF;
    localparam int          QUIET_GUARD = 80;      // covers the remainder unit's catch-up
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          RAND_ITEMS  = 380;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] now;
        logic [31:0] dsec;
        logic        cb;
        logic [15:0] tag;
    } t_req_word;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] tag;
        logic        cv;
        logic [63:0] cval;
        logic        last;
    } t_result;

    typedef struct {
        logic [63:0] expiry;
        logic [15:0] tag;
    } t_timer;

    // Directed row; a config row puts the register index in req, value in dsec
    typedef struct {
        bit          cfg;
        logic [1:0]  req;
        logic [63:0] now;
        logic [31:0] dsec;
        bit          cb;
        logic [15:0] tag;
        bit          typed;
        logic [1:0]  st;
        bit          cv;
        logic [63:0] cval;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic                   cfg_idx;
    logic [IV_W-1:0]        cfg_data;
    logic                   s_valid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_data;
    logic [1:0]             s_user;
    logic                   o_m_axis_tvalid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [1:0]             o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    // Predictor state
    logic [31:0] tick_iv;
    logic [31:0] ticks_sec;
    logic [63:0] tick_deadline;
    t_timer      timers[$];

    t_result     step_results[$];
    t_result     pending_words[$];
    t_row        rows[$];

    bit          src_idle;
    bit          sink_idle;
    int          sink_stall;
    int          seen_words;
    int          errors;
    int          cycle_count;
    int          req_count;
    int          word_count;
    int          cfg_count;
    int          directed_count;

    sorted_timer_event_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] compare_point();
        logic [63:0] c;
        c = tick_deadline;
        if (timers.size() > 0 && timers[0].expiry < c)
            c = timers[0].expiry;
        return c;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [1:0] status,
                                       logic [15:0] tag, logic cv, logic [63:0] cval,
                                       logic last);
        t_result r;
        r = '{kind, status, tag, cv, cval, last};
        step_results.push_back(r);
    endfunction

    // Work out the result words of one accepted request, update the state
    function automatic void predict_results(t_req_word w);
        logic [63:0] iv;
        logic [63:0] expiry;
        t_timer      t;
        int          pos;
        int          fired;
        iv = (tick_iv == 32'd0) ? 64'd1 : {32'd0, tick_iv};
        step_results.delete();
        case (w.req)
            REQ_START: begin
                timers.delete();
                tick_deadline = w.now + iv;
                add_result(KIND_COMPARE, ST_OK, 16'd0, 1'b1, compare_point(), 1'b1);
            end
            REQ_ADD: begin
                if (!w.cb || w.dsec[31]) begin
                    add_result(KIND_STATUS, ST_INVALID, 16'd0, 1'b0, 64'd0, 1'b1);
                end else if (timers.size() >= POOL) begin
                    add_result(KIND_STATUS, ST_FULL, 16'd0, 1'b0, 64'd0, 1'b1);
                end else begin
                    expiry = w.now + {32'd0, w.dsec} * {32'd0, ticks_sec};
                    // ties go behind earlier arrivals
                    pos = 0;
                    while (pos < timers.size() && timers[pos].expiry <= expiry)
                        pos++;
                    t = '{expiry, w.tag};
                    timers.insert(pos, t);
                    if (pos == 0)
                        add_result(KIND_STATUS, ST_OK, 16'd0, 1'b1, compare_point(), 1'b1);
                    else
                        add_result(KIND_STATUS, ST_OK, 16'd0, 1'b0, 64'd0, 1'b1);
                end
            end
            REQ_SERVICE: begin
                if (tick_deadline <= w.now)
                    tick_deadline = tick_deadline + ((w.now - tick_deadline) / iv + 64'd1) * iv;
                fired = 0;
                while (fired < FIRE_LIMIT && timers.size() > 0 && timers[0].expiry <= w.now) begin
                    add_result(KIND_FIRED, ST_OK, timers[0].tag, 1'b0, 64'd0, 1'b0);
                    void'(timers.pop_front());
                    fired++;
                end
                add_result(KIND_COMPARE, ST_OK, 16'd0, 1'b1, compare_point(), 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Result monitor
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            word_count++;
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected: kind %0h tdata %0h",
                       o_m_axis_tuser, o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_words.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(o_m_axis_tuser));
                check_field("add_status", 64'(want.status), 64'(o_m_axis_tdata[1:0]));
                check_field("fired_tag", 64'(want.tag), 64'(o_m_axis_tdata[17:2]));
                check_field("compare_valid", 64'(want.cv), 64'(o_m_axis_tdata[18]));
                check_field("compare_value", want.cval, o_m_axis_tdata[82:19]);
                check_field("last", 64'(want.last), 64'(o_m_axis_tlast));
            end
        end
    end

    // Receiver ready, changed on the falling edge only; a stall is drawn per word
    always @(negedge i_clk) begin : ready_driver
        if (word_count != seen_words) begin
            seen_words = word_count;
            sink_stall = sink_idle ? $urandom_range(0, 10) : 0;
        end
        if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one request word, predict on acceptance
    task automatic send_request(t_req_word w, bit typed, t_result want);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= w.req;
        s_data  <= {7'd0, w.tag, w.cb, w.dsec, w.now};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predict_results(w);
        if (typed) begin
            pending_words.push_back(want);
        end else begin
            foreach (step_results[i])
                pending_words.push_back(step_results[i]);
        end
        if (w.req != REQ_UNUSED)
            req_count++;
    endtask

    // Hold off the sender until every expected word is in, then a guard
    task automatic wait_quiet(int guard);
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (guard) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        wait_quiet(QUIET_GUARD);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx == CFG_TICK_INTERVAL)
            tick_iv = value;
        else
            ticks_sec = value;
        cfg_count++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return $urandom_range(1, 50);
            3: return TICK_INTERVAL_RST;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 4))
            0: return 32'd1;
            1: return $urandom_range(1, 100);
            2: return TICKS_PER_SEC_RST;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin : main
        t_req_word   w;
        t_result     want;
        t_result     none;
        logic [63:0] cur_time;
        int          pick;
        int          burst;

        cfg_we     = 1'b0;
        cfg_idx    = 1'b0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_user     = REQ_START;
        none       = '{KIND_STATUS, ST_OK, 16'd0, 1'b0, 64'd0, 1'b0};

        tick_iv       = TICK_INTERVAL_RST;
        ticks_sec     = TICKS_PER_SEC_RST;
        tick_deadline = 64'd0;
        timers.delete();

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // cfg, req/idx, now, delay/value, cb, tag, typed, status, cv, compare
        // add before any start: deadline still zero
        rows.push_back('{0, REQ_ADD, 64'd100, 32'd0, 1, 16'h1111, 1, ST_OK, 1, 64'd0});
        rows.push_back('{0, REQ_SERVICE, 64'd0, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_SERVICE, 64'd100, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_START, 64'd0, 32'd0, 0, 16'd0, 1, ST_OK, 1, 64'd750000});
        // rejected adds: no callback, negative delays
        rows.push_back('{0, REQ_ADD, 64'd5, 32'd3, 0, 16'h0001, 1, ST_INVALID, 0, 64'd0});
        rows.push_back('{0, REQ_ADD, 64'd5, 32'hFFFF_FFFF, 1, 16'h0002, 1, ST_INVALID, 0, 64'd0});
        rows.push_back('{0, REQ_ADD, 64'd5, 32'h8000_0000, 1, 16'h0003, 1, ST_INVALID, 0, 64'd0});
        rows.push_back('{0, REQ_ADD, 64'd5, 32'd0, 0, 16'hFFFF, 1, ST_INVALID, 0, 64'd0});
        // new head, then an equal expiry that queues behind it
        rows.push_back('{0, REQ_ADD, 64'd1000, 32'd0, 1, 16'h0000, 1, ST_OK, 1, 64'd1000});
        rows.push_back('{0, REQ_ADD, 64'd1000, 32'd0, 1, 16'hFFFF, 1, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_ADD, 64'd0, 32'h7FFF_FFFF, 1, 16'h8001, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_ADD, TIME_MAX, 32'd1, 1, 16'h7FFE, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_UNUSED, TIME_MAX, 32'hFFFF_FFFF, 1, 16'hFFFF, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_SERVICE, TIME_MAX, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        // zero interval counts as one
        rows.push_back('{1, CFG_TICK_INTERVAL, 64'd0, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_START, 64'd10, 32'd0, 0, 16'd0, 1, ST_OK, 1, 64'd11});
        rows.push_back('{0, REQ_SERVICE, 64'd20, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        // largest registers, deadline wraps past zero
        rows.push_back('{1, CFG_TICK_INTERVAL, 64'd0, 32'hFFFF_FFFF, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{1, CFG_TICKS_PER_SEC, 64'd0, 32'hFFFF_FFFF, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_START, TIME_MAX, 32'd0, 0, 16'd0, 1, ST_OK, 1, 64'hFFFF_FFFE});
        rows.push_back('{0, REQ_ADD, 64'd0, 32'h7FFF_FFFF, 1, 16'hAAAA, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_SERVICE, 64'hFFFF_FFFF_0000_0000, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        // smallest registers
        rows.push_back('{1, CFG_TICK_INTERVAL, 64'd0, 32'd1, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{1, CFG_TICKS_PER_SEC, 64'd0, 32'd1, 0, 16'd0, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_START, 64'd5, 32'd0, 0, 16'd0, 1, ST_OK, 1, 64'd6});
        rows.push_back('{0, REQ_ADD, 64'd5, 32'd3, 1, 16'h5555, 0, ST_OK, 0, 64'd0});
        rows.push_back('{0, REQ_SERVICE, 64'd8, 32'd0, 0, 16'd0, 0, ST_OK, 0, 64'd0});

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        foreach (rows[i]) begin
            if (rows[i].cfg) begin
                write_register(rows[i].req[0], rows[i].dsec);
            end else begin
                w    = '{rows[i].req, rows[i].now, rows[i].dsec, rows[i].cb, rows[i].tag};
                want = '{(rows[i].req == REQ_ADD) ? KIND_STATUS : KIND_COMPARE,
                         rows[i].st, 16'd0, rows[i].cv, rows[i].cval, 1'b1};
                send_request(w, rows[i].typed, want);
            end
        end
        directed_count = req_count;

        // Random phases: new settings, then either a mixed run or a fill burst
        while (req_count < directed_count + RAND_ITEMS) begin
            write_register(CFG_TICK_INTERVAL, pick_interval());
            write_register(CFG_TICKS_PER_SEC, pick_rate());
            src_idle  = $urandom_range(0, 2) != 0;
            sink_idle = $urandom_range(0, 2) != 0;
            cur_time  = $urandom_range(0, 1) ? {$urandom, $urandom} : {32'd0, $urandom};

            if ($urandom_range(0, 3) == 0) begin
                // fill the pool, overflow it, then expire everything
                w = '{REQ_START, cur_time, 32'd0, 1'b0, 16'd0};
                send_request(w, 0, none);
                burst = $urandom_range(POOL + 1, POOL + 4);
                repeat (burst) begin
                    w = '{REQ_ADD, cur_time, $urandom_range(0, 3),
                          $urandom_range(0, 15) != 0, 16'($urandom)};
                    send_request(w, 0, none);
                end
                w = '{REQ_SERVICE, cur_time + 64'd3 * {32'd0, ticks_sec}, 32'd0, 1'b0, 16'd0};
                send_request(w, 0, none);
                w.now = w.now + 64'd1;
                send_request(w, 0, none);
            end else begin
                if ($urandom_range(0, 4) != 0) begin
                    w = '{REQ_START, cur_time, 32'd0, 1'b0, 16'd0};
                    send_request(w, 0, none);
                end
                repeat (40) begin
                    // now and then let all expected result words drain
                    if ($urandom_range(0, 19) == 0)
                        wait_quiet(0);
                    pick = $urandom_range(0, 99);
                    w = '{REQ_ADD, cur_time, $urandom_range(0, 6), 1'b1, 16'($urandom)};
                    if (pick < 6)
                        w.req = REQ_START;
                    else if (pick < 60)
                        ;
                    else if (pick < 68)
                        w = '{REQ_ADD, {$urandom, $urandom}, $urandom,
                              $urandom_range(0, 1), 16'($urandom)};
                    else if (pick < 96)
                        w.req = REQ_SERVICE;
                    else
                        w = '{REQ_UNUSED, {$urandom, $urandom}, $urandom,
                              $urandom_range(0, 1), 16'($urandom)};
                    send_request(w, 0, none);
                    cur_time = cur_time + (({32'd0, ticks_sec} * $urandom_range(0, 3)) >> 1)
                               + $urandom_range(0, 3);
                end
            end
        end

        wait_quiet(QUIET_GUARD);
        $display("Covered %0d requests (%0d directed) and %0d result words",
                 req_count, directed_count, word_count);
        $display("across %0d register writes; %0d mismatches", cfg_count, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
